// File: sv/vgw_pkg.sv
// Shared types and constants for the vertex grid weld block.
package vgw_pkg;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

  localparam logic [0:0] REG_GRID_SCALE = 1'd0;
  localparam logic [0:0] REG_WELD_ENABLE = 1'd1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_QUANT = 11'b00000000010,
    ST_HASH  = 11'b00000000100,
    ST_HMUL  = 11'b00000001000,
    ST_PROBE = 11'b00000010000,
    ST_CMP   = 11'b00000100000,
    ST_DONE  = 11'b00001000000,
    ST_CLEAR = 11'b00010000000,
    ST_MULW  = 11'b00100000000,
    ST_HACC  = 11'b01000000000,
    ST_RES   = 11'b10000000000
  } state_t;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_op_t;
endpackage

// File: sv/vgw_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module vgw_mul (
  input  logic            clk,
  input  vgw_pkg::mul_op_t op,
  output logic [63:0]     prod
);
  import vgw_pkg::*;
  always_ff @(posedge clk) begin
    prod <= 64'(op.a) * 64'(op.b);
  end
endmodule

// File: sv/vgw_table.sv
// Slot memory holding the cell triple and assigned index, one port.
module vgw_table #(
  parameter int SLOTS = 8192,
  parameter int IW = 12
) (
  input  logic                     clk,
  input  logic [$clog2(SLOTS)-1:0] addr,
  input  logic                     we,
  input  logic [96+IW-1:0]         wdata,
  output logic [96+IW-1:0]         rdata
);
  import vgw_pkg::*;
  logic [96+IW-1:0] mem [SLOTS];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/vertex_grid_weld.sv
// Top level of the vertex grid weld block: sequencer, counters and APB port.
// One vertex at a time: start is taken only in idle. When welding, the shared 32x32
//   multiplier does three quantizing products and two partial products per FNV round.
// Reset and every end-of-mesh item start a clear of all TABLE_SLOTS valid bits;
//   receiver cannot stall.
module vertex_grid_weld #(
  parameter int MAX_VERTICES = 4096,
  parameter int TABLE_SLOTS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic        end_of_mesh,
  output logic        done,
  output logic [11:0] vertex_index,
  output logic        is_new,
  output logic        overflow,
  output logic [12:0] merged_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vgw_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = 12;

  // ---------------- configuration ----------------
  logic [31:0] grid_scale;
  logic        weld_enable;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale  <= 32'd65536;
      weld_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GRID_SCALE:  grid_scale <= pwdata;
        REG_WELD_ENABLE: weld_enable <= pwdata[0];
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      REG_GRID_SCALE:  prdata = grid_scale;
      REG_WELD_ENABLE: prdata = {31'd0, weld_enable};
    endcase
  end

  // ---------------- state ----------------
  state_t      state;
  logic [1:0]  axis;      // coordinate / FNV round being worked on
  logic [2:0]  part;      // partial-product step of the 64-bit multiply
  logic [31:0] crd [3];
  logic [31:0] grid_cell [3];
  logic        eom;
  logic [63:0] h, hacc;
  logic [AW-1:0] slot;
  logic [AW:0]   probes;
  logic [CW-1:0] distinct_count, seen_count;
  logic [AW-1:0] clr_addr;
  logic          clr_first;

  // Valid bits live in their own memory so the clearing pass can sweep them.
  logic       vmem [TABLE_SLOTS];
  logic       vrd;
  logic [AW-1:0] vaddr;
  logic       vwe, vwd;

  mul_op_t     mop;
  logic [63:0] prod;
  vgw_mul u_mul (.clk(clk), .op(mop), .prod(prod));

  logic          twe;
  logic [96+IW-1:0] twd, trd;
  vgw_table #(.SLOTS(TABLE_SLOTS), .IW(IW)) u_tab (
    .clk(clk), .addr(slot), .we(twe), .wdata(twd), .rdata(trd)
  );

  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vwd;
    vrd <= vmem[vaddr];
  end

  // Magnitude of the current coordinate.
  logic [31:0] mag;
  logic        neg;
  assign neg = crd[axis][31];
  assign mag = neg ? (~crd[axis] + 32'd1) : crd[axis];

  // Rounded cell from the registered product.
  logic [32:0] rnd;
  logic [31:0] qcell;
  logic        qneg;
  assign rnd = 33'(({1'b0, prod} + 65'h80000000) >> 32);
  always_comb begin
    if (qneg) qcell = (rnd >= 33'h80000000) ? 32'h80000000 : (~rnd[31:0] + 32'd1);
    else      qcell = (rnd > 33'h7FFFFFFF) ? 32'h7FFFFFFF : rnd[31:0];
  end

  // FNV multiply: h * prime over partials; prime = 2^40 + 0x1B3, so use
  // h*0x1B3 via the multiplier in two halves and add the shift.
  logic [63:0] hx;
  assign hx = h ^ {{32{grid_cell[axis][31]}}, grid_cell[axis]};
  always_comb begin
    mop.a = mag;
    mop.b = grid_scale;
    if (state == ST_HASH || state == ST_HMUL || state == ST_HACC) begin
      mop.a = part[0] ? hx[63:32] : hx[31:0];
      mop.b = FNV_PRIME[31:0];
    end
  end

  logic match;
  assign match = trd[96+IW-1:IW+64] == grid_cell[0] && trd[IW+63:IW+32] == grid_cell[1] &&
                 trd[IW+31:IW] == grid_cell[2];

  // Write only once the read data for the probed slot is valid.
  always_comb begin
    vaddr = (state == ST_CLEAR) ? clr_addr : slot;
    vwe = 1'b0;
    vwd = 1'b0;
    twe = 1'b0;
    twd = {grid_cell[0], grid_cell[1], grid_cell[2], IW'(distinct_count)};
    if (state == ST_CLEAR) vwe = 1'b1;
    if (state == ST_CMP && !clr_first && !vrd && distinct_count < CW'(MAX_VERTICES)) begin
      vwe = 1'b1; vwd = 1'b1; twe = 1'b1;
    end
  end

  logic [CW-1:0] merged;
  assign merged = seen_count - distinct_count;

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      distinct_count <= '0;
      seen_count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) begin
          crd[0] <= coord_x; crd[1] <= coord_y; crd[2] <= coord_z;
          eom <= end_of_mesh;
          axis <= 2'd0;
          if (seen_count >= CW'(MAX_VERTICES)) begin
            // Mesh too long: report overflow, counters unchanged.
            vertex_index <= '0; is_new <= 1'b0; overflow <= 1'b1;
            state <= ST_RES;
          end else if (!weld_enable) begin
            vertex_index <= IW'(distinct_count); is_new <= 1'b1; overflow <= 1'b0;
            distinct_count <= distinct_count + 1'b1;
            seen_count <= seen_count + 1'b1;
            state <= ST_RES;
          end else begin
            state <= ST_MULW;
          end
        end
        ST_MULW: begin
          // Multiplier loads this cycle; product valid next.
          qneg <= neg;
          state <= ST_QUANT;
        end
        ST_QUANT: begin
          grid_cell[axis] <= qcell;
          if (axis == 2'd2) begin
            axis <= 2'd0; h <= FNV_BASIS; part <= 3'd0; state <= ST_HASH;
          end else begin
            axis <= axis + 2'd1; state <= ST_MULW;
          end
        end
        ST_HASH: begin
          // Low half of (h^w)*0x1B3 enters the multiplier.
          part <= 3'd1; state <= ST_HMUL;
        end
        ST_HMUL: begin
          hacc <= prod + {hx[23:0], 40'd0};
          part <= 3'd2; state <= ST_HACC;
        end
        ST_HACC: begin
          // High half contributes its low 32 bits at bit 32.
          h <= hacc + {prod[31:0], 32'd0};
          part <= 3'd0;
          if (axis == 2'd2) begin
            state <= ST_PROBE;
          end else begin
            axis <= axis + 2'd1; state <= ST_HASH;
          end
        end
        ST_PROBE: begin
          if (axis == 2'd2) begin
            slot <= AW'(h);
            axis <= 2'd0;
            probes <= '0;
          end
          state <= ST_CMP;
        end
        ST_CMP: begin
          // Read data for slot is registered, valid in the cycle after the address.
          if (clr_first) begin
            clr_first <= 1'b0;
          end else if (!vrd) begin
            if (distinct_count < CW'(MAX_VERTICES)) begin
              vertex_index <= IW'(distinct_count); is_new <= 1'b1; overflow <= 1'b0;
              distinct_count <= distinct_count + 1'b1;
              seen_count <= seen_count + 1'b1;
            end else begin
              vertex_index <= '0; is_new <= 1'b0; overflow <= 1'b1;
            end
            state <= ST_RES;
          end else if (match) begin
            vertex_index <= trd[IW-1:0]; is_new <= 1'b0; overflow <= 1'b0;
            seen_count <= seen_count + 1'b1;
            state <= ST_RES;
          end else if (probes == (AW+1)'(TABLE_SLOTS - 1)) begin
            vertex_index <= '0; is_new <= 1'b0; overflow <= 1'b1;
            state <= ST_RES;
          end else begin
            slot <= slot + 1'b1;
            probes <= probes + 1'b1;
            clr_first <= 1'b1;
          end
        end
        ST_RES: state <= ST_DONE;
        ST_DONE: begin
          done <= 1'b1;
          merged_count <= 13'(merged);
          if (eom) begin
            distinct_count <= '0; seen_count <= '0;
            clr_addr <= '0; state <= ST_CLEAR;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_SLOTS - 1)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_PROBE) clr_first <= 1'b1;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    done && is_new |-> !overflow) else $error("new vertex flagged overflow");
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> vertex_index == '0) else $error("overflow index not zero");
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    seen_count >= distinct_count) else $error("seen below distinct");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without an item");
endmodule
